// File: rtl/sfpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor frame parser.
// No dependencies; every other file in rtl imports this package.
package sfpa_pkg;

  localparam int FRAME_LEN    = 17;
  localparam int BUFFER_LIMIT = 20;
  localparam int CNT_W        = $clog2(BUFFER_LIMIT + 1);
  localparam int IDX_W        = $clog2(FRAME_LEN);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TEMP_W = 8;
  localparam int RATE_W = 9;
  localparam int CFG_W  = RATE_W;
  localparam int CIDX_W = 3;

  localparam logic [7:0] HDR0 = 8'hA0;
  localparam logic [7:0] HDR1 = 8'h0A;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] CFG_TEMP_LOW  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TEMP_HIGH = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TEMP_WARN = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RATE_LOW  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_RATE_HIGH = 3'd4;

  localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 8'd20;
  localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 8'd40;
  localparam logic [TEMP_W-1:0] TEMP_WARN_RST = 8'd37;
  localparam logic [RATE_W-1:0] RATE_LOW_RST  = 9'd50;
  localparam logic [RATE_W-1:0] RATE_HIGH_RST = 9'd300;

  // Status codes of a result.
  localparam logic [1:0] ST_RESP    = 2'd0;
  localparam logic [1:0] ST_HDR_ERR = 2'd1;
  localparam logic [1:0] ST_OVF_ERR = 2'd2;

  // One unit of work from the parser to the response generator.
  typedef struct packed {
    logic [1:0]  status;
    logic        checksum_ok;
    logic        emergency;
    logic [7:0]  device_id;
    logic [15:0] light_level;
    logic [7:0]  temperature;
    logic [7:0]  heart_rate;
    logic [7:0]  menu_code;
    logic [7:0]  resp4;
    logic [7:0]  resp5;
    logic [7:0]  resp6;
    logic [7:0]  resp7;
  } job_t;

endpackage

// File: rtl/sfpa_front.sv
`timescale 1ns / 1ps
// Byte parser: framing, checksum, held heart rate and alarm classification.
// Depends on sfpa_pkg; pushes one job_t per frame or framing error.
module sfpa_front import sfpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              rx_valid,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              in_frame;
  logic [7:0]        held_rate;
  logic [7:0]        b0, b3, b4, b5, b6, b7, b8, b14, b15;
  logic [7:0]        sum;
  logic [TEMP_W-1:0] temp_low, temp_high, temp_warn;
  logic [RATE_W-1:0] rate_low, rate_high;

  logic       take;
  logic       frame_done;
  logic       ovf;
  logic       hdr_check;
  logic       hdr_ok;
  logic [7:0] rate_new;
  logic       temp_emerg;
  logic       temp_warn_hit;
  logic       rate_emerg;
  logic       emerg;
  job_t       job;

  assign take    = rx_valid && !q_full;
  assign cnt_inc = cnt + 1'b1;

  assign frame_done = in_frame && (cnt_inc == CNT_W'(FRAME_LEN))
                      && (b15 == HDR1) && (rx_byte == HDR0);
  assign ovf        = in_frame && !frame_done && (cnt_inc >= CNT_W'(BUFFER_LIMIT));
  assign hdr_check  = !in_frame && (cnt_inc == CNT_W'(2));
  assign hdr_ok     = (b0 == HDR0) && (rx_byte == HDR1);

  assign rate_new      = (b7 != 8'd0) ? b7 : held_rate;
  assign temp_emerg    = (b6 > temp_high) || (b6 < temp_low);
  assign temp_warn_hit = !temp_emerg && (b6 > temp_warn);
  assign rate_emerg    = (rate_new != 8'd0) &&
                         (({1'b0, rate_new} < rate_low) || ({1'b0, rate_new} > rate_high));
  assign emerg         = temp_emerg || rate_emerg;

  always_comb begin
    job = '0;
    job.resp6 = 8'hFF;
    if (frame_done) begin
      job.status      = ST_RESP;
      job.checksum_ok = (sum == b14);
      job.emergency   = emerg;
      job.device_id   = b3;
      job.light_level = {b4, b5};
      job.temperature = b6;
      job.heart_rate  = rate_new;
      job.menu_code   = b8;
      if (b8 != 8'd0) begin
        job.resp5 = 8'hFF;
        job.resp6 = 8'h00;
      end
      if (temp_warn_hit) begin
        job.resp4 = 8'hFF;
        job.resp5 = 8'hFF;
        job.resp6 = 8'h00;
      end
      if (emerg) begin
        job.resp4 = 8'hFF;
        job.resp5 = 8'h00;
        job.resp6 = 8'h00;
        job.resp7 = 8'h01;
      end
    end else begin
      job.resp6  = 8'h00;
      job.status = ovf ? ST_OVF_ERR : ST_HDR_ERR;
    end
  end

  assign push     = take && (frame_done || ovf || (hdr_check && !hdr_ok));
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low  <= TEMP_LOW_RST;
      temp_high <= TEMP_HIGH_RST;
      temp_warn <= TEMP_WARN_RST;
      rate_low  <= RATE_LOW_RST;
      rate_high <= RATE_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEMP_LOW:  temp_low  <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_HIGH: temp_high <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_WARN: temp_warn <= cfg_data[TEMP_W-1:0];
        CFG_RATE_LOW:  rate_low  <= cfg_data[RATE_W-1:0];
        CFG_RATE_HIGH: rate_high <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      in_frame  <= 1'b0;
      held_rate <= '0;
    end else if (take) begin
      if (frame_done) begin
        cnt       <= '0;
        in_frame  <= 1'b0;
        held_rate <= rate_new;
      end else if (ovf) begin
        cnt      <= '0;
        in_frame <= 1'b0;
      end else if (hdr_check) begin
        cnt      <= hdr_ok ? cnt_inc : '0;
        in_frame <= hdr_ok;
      end else begin
        cnt <= cnt_inc;
      end
    end
  end

  // Frame bytes are kept only where the decode needs them.
  always_ff @(posedge clk) begin
    if (take) begin
      if (cnt == CNT_W'(0))  b0  <= rx_byte;
      if (cnt == CNT_W'(3))  b3  <= rx_byte;
      if (cnt == CNT_W'(4))  b4  <= rx_byte;
      if (cnt == CNT_W'(5))  b5  <= rx_byte;
      if (cnt == CNT_W'(6))  b6  <= rx_byte;
      if (cnt == CNT_W'(7))  b7  <= rx_byte;
      if (cnt == CNT_W'(8))  b8  <= rx_byte;
      if (cnt == CNT_W'(14)) b14 <= rx_byte;
      if (cnt == CNT_W'(15)) b15 <= rx_byte;
      if (hdr_check) begin
        sum <= '0;
      end else if (in_frame && cnt >= CNT_W'(2) && cnt <= CNT_W'(13)) begin
        sum <= sum + rx_byte;
      end
    end
  end

  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (cnt >= CNT_W'(2)))
    else $error("in_frame set with fewer than two bytes held");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (cnt < CNT_W'(2)))
    else $error("byte count grew past the header without a frame");

endmodule

// File: rtl/sfpa_queue.sv
`timescale 1ns / 1ps
// Short job queue between the parser and the response generator.
// Depends on sfpa_pkg for job_t and the queue depth.
module sfpa_queue import sfpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job popped from an empty queue");

endmodule

// File: rtl/sfpa_back.sv
`timescale 1ns / 1ps
// Response generator: expands each queued job into its results.
// Depends on sfpa_pkg; drives the registered output channel.
module sfpa_back import sfpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        head,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [7:0]  resp_byte,
  output logic        last,
  output logic        checksum_ok,
  output logic        emergency,
  output logic [7:0]  device_id,
  output logic [15:0] light_level,
  output logic [7:0]  temperature,
  output logic [7:0]  heart_rate,
  output logic [7:0]  menu_code
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             is_frame;
  logic             frame_end;
  logic [7:0]       byte_sel;

  assign load      = (!out_valid || !out_stall) && !q_empty;
  assign is_frame  = (head.status == ST_RESP);
  assign frame_end = (idx == IDX_W'(FRAME_LEN - 1));
  assign pop       = load && (!is_frame || frame_end);

  always_comb begin
    unique case (idx)
      IDX_W'(0):             byte_sel = HDR0;
      IDX_W'(1):             byte_sel = HDR1;
      IDX_W'(4):             byte_sel = head.resp4;
      IDX_W'(5):             byte_sel = head.resp5;
      IDX_W'(6):             byte_sel = head.resp6;
      IDX_W'(7):             byte_sel = head.resp7;
      IDX_W'(FRAME_LEN - 2): byte_sel = HDR1;
      IDX_W'(FRAME_LEN - 1): byte_sel = HDR0;
      default:               byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= head.status;
      resp_byte   <= is_frame ? byte_sel : 8'h00;
      last        <= !is_frame || frame_end;
      checksum_ok <= head.checksum_ok;
      emergency   <= head.emergency;
      device_id   <= head.device_id;
      light_level <= head.light_level;
      temperature <= head.temperature;
      heart_rate  <= head.heart_rate;
      menu_code   <= head.menu_code;
    end
  end

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_RESP) |-> last)
    else $error("status result without last");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(FRAME_LEN - 1))
    else $error("response byte index out of range");

endmodule

// File: rtl/sensor_frame_parser_alarm.sv
`timescale 1ns / 1ps
// The job for a frame or framing error enters the queue at the edge that accepts
//   the byte causing it; its first result is then loaded into the output registers.
// Throughput: one received byte per cycle; rx_stall rises only while the 2-entry job
//   queue is full; the generator drains it at one result per cycle when out_stall is low.
// Reset (rst, synchronous, active high) clears framing state, held heart rate, the job
//   queue and out_valid, and returns the five limit registers to their defaults.
//
// Structure. The front parser takes one rx_byte per transaction, tracks the header,
// counts bytes, keeps a running byte sum of bytes 2..13 and the few frame bytes that
// the decode needs. On the byte that completes a frame it updates the held heart
// rate, classifies the temperature and heart-rate alarms against the limit registers
// and pushes one job describing the whole response. A bad header or a frame that runs
// to the buffer limit pushes a status job instead.
//
// The back generator turns the job at the head of the queue into results: seventeen
// response bytes for a frame, one status result for a framing error. Its output
// register lets the next transaction be loaded whenever the current one is taken.
//
// Configuration writes go straight to the limit registers; they are only expected
// while no transaction is in flight.
module sensor_frame_parser_alarm import sfpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [7:0]        resp_byte,
  output logic              last,
  output logic              checksum_ok,
  output logic              emergency,
  output logic [7:0]        device_id,
  output logic [15:0]       light_level,
  output logic [7:0]        temperature,
  output logic [7:0]        heart_rate,
  output logic [7:0]        menu_code
);

  // Job handoff between the parser and the response generator.
  logic push;
  job_t push_job;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t head;

  // The parser stalls only when it has nowhere to put a job.
  assign rx_stall = q_full;

  sfpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  sfpa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  sfpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .resp_byte   (resp_byte),
    .last        (last),
    .checksum_ok (checksum_ok),
    .emergency   (emergency),
    .device_id   (device_id),
    .light_level (light_level),
    .temperature (temperature),
    .heart_rate  (heart_rate),
    .menu_code   (menu_code)
  );

endmodule
